### src/prenv_pkg.sv
// ----------------------------------------------------------------------------
// prenv_pkg
// Shared widths for the peak / RMS envelope follower and its serial units.
// ----------------------------------------------------------------------------
package prenv_pkg;

  // Default channel count of the top level
  localparam int unsigned CHANNELS_DEF = 8;

  // Field widths
  localparam int unsigned CHAN_IDX_W = 4;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned COEF_W     = 16;

  // Stored envelope (Q16.8) and mean square (Q32.8)
  localparam int unsigned FRAC_W = 8;
  localparam int unsigned ENV_W  = 24;
  localparam int unsigned MS_W   = 40;

  // Multiplicand of the serial multiplier: signed difference of two means
  localparam int unsigned MUL_W = MS_W + 1;

  // Root of the mean square
  localparam int unsigned ROOT_W = MS_W / 2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RMS_SELECT = 2'd0,
    CFG_ATTACK     = 2'd1,
    CFG_RELEASE    = 2'd2
  } cfg_reg_e;

endpackage

### src/prenv_mul.sv
// ----------------------------------------------------------------------------
// prenv_mul
// Bit-serial signed by unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module prenv_mul (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [prenv_pkg::MUL_W-1:0]   mcand_i,
  input  logic        [prenv_pkg::COEF_W-1:0]  mplier_i,
  output logic                                 done_o,
  output logic signed [prenv_pkg::MUL_W:0]     prod_hi_o,
  output logic        [prenv_pkg::COEF_W-1:0]  prod_lo_o
);

  localparam int unsigned CntW = $clog2(prenv_pkg::COEF_W + 1);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [CntW-1:0]                     cnt_q, cnt_d;
  logic signed [prenv_pkg::MUL_W:0]    acc_q, acc_d;
  logic [prenv_pkg::COEF_W-1:0]        lo_q, lo_d;
  logic [prenv_pkg::MUL_W-1:0]         mcand_q, mcand_d;
  logic signed [prenv_pkg::MUL_W:0]    sum;

  // Add the multiplicand on a set bit, then shift the pair right by one
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    lo_d    = lo_q;
    mcand_d = mcand_q;
    sum     = acc_q + (lo_q[0] ? {mcand_q[prenv_pkg::MUL_W-1], mcand_q}
                               : {(prenv_pkg::MUL_W + 1){1'b0}});
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = CntW'(prenv_pkg::COEF_W);
      acc_d   = '0;
      lo_d    = mplier_i;
      mcand_d = mcand_i;
    end else if (busy_q) begin
      acc_d = sum >>> 1;
      lo_d  = {sum[0], lo_q[prenv_pkg::COEF_W-1:1]};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold datapath
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    lo_q    <= lo_d;
    mcand_q <= mcand_d;
  end

  assign done_o    = done_q;
  assign prod_hi_o = acc_q;
  assign prod_lo_o = lo_q;

endmodule

### src/prenv_sqrt.sv
// ----------------------------------------------------------------------------
// prenv_sqrt
// Restoring square root, two radicand bits and one root bit per cycle.
// ----------------------------------------------------------------------------
module prenv_sqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [prenv_pkg::MS_W-1:0]      radicand_i,
  output logic                            done_o,
  output logic [prenv_pkg::ROOT_W-1:0]    root_o
);

  localparam int unsigned CntW  = $clog2(prenv_pkg::ROOT_W + 1);
  localparam int unsigned RemW  = prenv_pkg::ROOT_W + 2;
  localparam int unsigned TrialW = RemW + 2;

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [prenv_pkg::MS_W-1:0]    rad_q, rad_d;
  logic [RemW-1:0]               rem_q, rem_d;
  logic [prenv_pkg::ROOT_W-1:0]  root_q, root_d;
  logic [TrialW-1:0]             rem_sh;
  logic [TrialW-1:0]             trial;
  logic [TrialW-1:0]             diff;
  logic                          fits;

  // Bring down two bits, try root*4+1, keep the difference when it fits
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    rem_sh = {rem_q, rad_q[prenv_pkg::MS_W-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
    diff   = rem_sh - trial;
    fits   = (rem_sh >= trial);
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(prenv_pkg::ROOT_W);
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d  = {rad_q[prenv_pkg::MS_W-3:0], 2'b00};
      rem_d  = fits ? diff[RemW-1:0] : rem_sh[RemW-1:0];
      root_d = {root_q[prenv_pkg::ROOT_W-2:0], fits};
      cnt_d  = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold datapath
  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### src/peak_rms_envelope_follower_unit.sv
// ----------------------------------------------------------------------------
// peak_rms_envelope_follower_unit
// Per-channel peak or RMS envelope follower on a stream of audio words.
// ----------------------------------------------------------------------------
// The block takes one word at a time and returns that channel's new envelope.
// A peak-mode word takes one pass of the bit-serial coefficient multiplier,
// then write-back of the envelope and the result register. An RMS-mode word
// takes a serial square of the sample, a serial coefficient multiply and a
// restoring square root, in that order. The input side takes the next word
// as soon as a result has moved to the output register, even while that
// result still waits, but not before. Channel state clears at reset with no
// sweep.
// ----------------------------------------------------------------------------
module peak_rms_envelope_follower_unit #(
  parameter int unsigned CHANNELS = prenv_pkg::CHANNELS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input words
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [23:0]                         s_axis_tdata,  // channel_index, sample_value
  // Result words
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [15:0]                         m_axis_tdata,  // envelope_level
  // Configuration writes
  input  logic                                cfg_we_i,
  input  logic [prenv_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [prenv_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned ChW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SqW     = 2 * prenv_pkg::SAMPLE_W - 1;
  localparam int unsigned Sq8W    = SqW + prenv_pkg::FRAC_W;
  localparam int unsigned PeakDW  = prenv_pkg::ENV_W + 1;
  localparam int unsigned UpdW    = prenv_pkg::MUL_W + 1;
  localparam int unsigned ShiftW  = prenv_pkg::ROOT_W - prenv_pkg::LEVEL_W;
  localparam logic [prenv_pkg::CHAN_IDX_W:0] ChanLim =
    (prenv_pkg::CHAN_IDX_W + 1)'(CHANNELS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_MULT,
    ST_ROOT,
    ST_OUT
  } state_e;

  // Configuration
  logic                           rms_sel_q;
  logic [prenv_pkg::COEF_W-1:0]   attack_q;
  logic [prenv_pkg::COEF_W-1:0]   release_q;

  // Channel state
  logic [prenv_pkg::ENV_W-1:0]    peak_store_q [CHANNELS];
  logic [prenv_pkg::MS_W-1:0]     ms_store_q   [CHANNELS];

  // Control and payload
  state_e                         state_q, state_d;
  logic                           mode_q, mode_d;
  logic [ChW-1:0]                 ch_q, ch_d;
  logic [prenv_pkg::MUL_W-1:0]    base_q, base_d;
  logic [prenv_pkg::LEVEL_W-1:0]  res_q, res_d;
  logic                           out_valid_q, out_valid_d;
  logic [prenv_pkg::LEVEL_W-1:0]  out_level_q, out_level_d;

  // Datapath
  logic [prenv_pkg::CHAN_IDX_W-1:0] ch_in;
  logic [prenv_pkg::SAMPLE_W-1:0]   raw;
  logic [prenv_pkg::SAMPLE_W-1:0]   mag;
  logic [ChW-1:0]                   ch_sel;
  logic                             s_accept;
  logic [prenv_pkg::ENV_W-1:0]      env_rd;
  logic [prenv_pkg::ENV_W-1:0]      a8;
  logic                             rising;
  logic [PeakDW-1:0]                peak_diff;
  logic [Sq8W-1:0]                  sq8;
  logic [prenv_pkg::MUL_W-1:0]      rms_diff;
  logic [UpdW-1:0]                  upd;
  logic [prenv_pkg::LEVEL_W-1:0]    root_level;

  // Serial units
  logic                                mul_start;
  logic signed [prenv_pkg::MUL_W-1:0]  mul_mcand;
  logic [prenv_pkg::COEF_W-1:0]        mul_mplier;
  logic                                mul_done;
  logic signed [prenv_pkg::MUL_W:0]    prod_hi;
  logic [prenv_pkg::COEF_W-1:0]        prod_lo;
  logic                                sqrt_start;
  logic                                sqrt_done;
  logic [prenv_pkg::ROOT_W-1:0]        root;

  logic                                peak_we;
  logic                                ms_we;
  logic                                rms_peak_we;

  prenv_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .mcand_i   (mul_mcand),
    .mplier_i  (mul_mplier),
    .done_o    (mul_done),
    .prod_hi_o (prod_hi),
    .prod_lo_o (prod_lo)
  );

  prenv_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (upd[prenv_pkg::MS_W-1:0]),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  // Unpack the input word, clamp the channel, take the magnitude
  assign ch_in    = s_axis_tdata[prenv_pkg::CHAN_IDX_W-1:0];
  assign raw      = s_axis_tdata[prenv_pkg::CHAN_IDX_W +: prenv_pkg::SAMPLE_W];
  assign mag      = raw[prenv_pkg::SAMPLE_W-1] ? (~raw + prenv_pkg::SAMPLE_W'(1)) : raw;
  assign ch_sel   = ({1'b0, ch_in} >= ChanLim) ? ChW'(CHANNELS - 1) : ch_in[ChW-1:0];
  assign s_accept = s_axis_tvalid && (state_q == ST_IDLE);

  // Peak setup: direction and difference to the new magnitude
  assign env_rd    = peak_store_q[ch_sel];
  assign a8        = {mag, {prenv_pkg::FRAC_W{1'b0}}};
  assign rising    = (a8 > env_rd);
  assign peak_diff = {1'b0, env_rd} - {1'b0, a8};

  // RMS setup: squared sample in Q.8 and difference to the stored mean
  assign sq8      = {prod_hi[SqW-prenv_pkg::COEF_W-1:0], prod_lo, {prenv_pkg::FRAC_W{1'b0}}};
  assign rms_diff = {1'b0, ms_store_q[ch_q]} - {{(prenv_pkg::MUL_W - Sq8W){1'b0}}, sq8};

  // Update: base + round(c * (old - base) / 2^16), rounding half up
  assign upd = {1'b0, base_q} + prod_hi + {{(UpdW - 1){1'b0}}, prod_lo[prenv_pkg::COEF_W-1]};

  assign root_level = root[ShiftW +: prenv_pkg::LEVEL_W];

  // Sequence one word through the serial units
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    ch_d        = ch_q;
    base_d      = base_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_level_d = out_level_q;
    mul_start   = 1'b0;
    mul_mcand   = {{(prenv_pkg::MUL_W - PeakDW){peak_diff[PeakDW-1]}}, peak_diff};
    mul_mplier  = rising ? attack_q : release_q;
    sqrt_start  = 1'b0;
    peak_we     = 1'b0;
    ms_we       = 1'b0;
    rms_peak_we = 1'b0;

    // Drop the result once taken
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          mode_d    = rms_sel_q;
          ch_d      = ch_sel;
          mul_start = 1'b1;
          if (rms_sel_q) begin
            mul_mcand  = {{(prenv_pkg::MUL_W - prenv_pkg::SAMPLE_W){1'b0}}, mag};
            mul_mplier = mag;
            state_d    = ST_SQUARE;
          end else begin
            base_d  = {{(prenv_pkg::MUL_W - prenv_pkg::ENV_W){1'b0}}, a8};
            state_d = ST_MULT;
          end
        end
      end
      ST_SQUARE: begin
        mul_mcand  = rms_diff;
        mul_mplier = release_q;
        if (mul_done) begin
          mul_start = 1'b1;
          base_d    = {{(prenv_pkg::MUL_W - Sq8W){1'b0}}, sq8};
          state_d   = ST_MULT;
        end
      end
      ST_MULT: begin
        if (mul_done) begin
          if (mode_q) begin
            ms_we      = 1'b1;
            sqrt_start = 1'b1;
            state_d    = ST_ROOT;
          end else begin
            peak_we = 1'b1;
            res_d   = upd[prenv_pkg::FRAC_W +: prenv_pkg::LEVEL_W];
            state_d = ST_OUT;
          end
        end
      end
      ST_ROOT: begin
        if (sqrt_done) begin
          rms_peak_we = 1'b1;
          res_d       = root_level;
          state_d     = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_level_d = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_level_q <= '0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
      out_level_q <= out_level_d;
    end
  end

  // Hold word payload
  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    base_q <= base_d;
    res_q  <= res_d;
  end

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rms_sel_q <= 1'b0;
      attack_q  <= '0;
      release_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        prenv_pkg::CFG_RMS_SELECT: rms_sel_q <= cfg_data_i[0];
        prenv_pkg::CFG_ATTACK:     attack_q  <= cfg_data_i[prenv_pkg::COEF_W-1:0];
        prenv_pkg::CFG_RELEASE:    release_q <= cfg_data_i[prenv_pkg::COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Update channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        peak_store_q[i] <= '0;
        ms_store_q[i]   <= '0;
      end
    end else begin
      if (peak_we) begin
        peak_store_q[ch_q] <= upd[prenv_pkg::ENV_W-1:0];
      end
      if (rms_peak_we) begin
        peak_store_q[ch_q] <= {root_level, {prenv_pkg::FRAC_W{1'b0}}};
      end
      if (ms_we) begin
        ms_store_q[ch_q] <= upd[prenv_pkg::MS_W-1:0];
      end
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_level_q;

endmodule

### src/prenv_checker.sv
// ----------------------------------------------------------------------------
// prenv_checker
// Port-level checks for the envelope follower, bound to the top level.
// ----------------------------------------------------------------------------
module prenv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  logic s_take;
  assign s_take = s_axis_tvalid && s_axis_tready;

  // A stalled result word holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // Envelope never exceeds the largest sample magnitude
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata <= 16'd32768))
    else $error("envelope level out of range");

  // One word in flight: input closes right after acceptance
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_take |=> !s_axis_tready)
    else $error("second word accepted while busy");

  // A new result frees the input side at once
  a_free_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("input not ready after result");

  // A result cannot appear the cycle after a word is taken
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_take |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

endmodule

bind peak_rms_envelope_follower_unit prenv_checker u_prenv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
